[rtl/core/grvn_pkg.sv]
// ----------------------------------------------------------------------------
// grvn_pkg
// shared constants for the grid vertex normal block
// ----------------------------------------------------------------------------
package grvn_pkg;

    localparam int MAX_WIDTH_DEF        = 1024;
    localparam int COORD_BITS_DEF       = 24;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam int GRID_W_BITS   = 11;
    localparam int GRID_H_BITS   = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = 8'd1;

    localparam logic [GRID_W_BITS-1:0] GRID_W_RST = 11'd64;
    localparam logic [GRID_H_BITS-1:0] GRID_H_RST = 16'd64;

    localparam int ACC_BITS = 64;
    localparam int MUL_BITS = 32;

endpackage

[rtl/core/grvn_ram.sv]
// ----------------------------------------------------------------------------
// grvn_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module grvn_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/grvn_norm.sv]
// ----------------------------------------------------------------------------
// grvn_norm
// newell sum over a loop of up to four points and unit normal, one shared
// multiplier, bit serial square root and divider
// ----------------------------------------------------------------------------
module grvn_norm #(
    parameter int COORD_BITS       = grvn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = grvn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [COORD_BITS-1:0]  i_pts [4][3],
    input  logic [2:0]                    i_cnt,
    output logic                          o_done,
    output logic                          o_degen,
    output logic [NORMAL_FRAC_BITS+1:0]   o_norm [3]
);
    import grvn_pkg::*;

    localparam int PRE = (COORD_BITS > 29) ? COORD_BITS - 29 : 0;
    localparam int DW  = COORD_BITS + 1 - PRE;
    localparam int NB  = NORMAL_FRAC_BITS + 2;
    localparam int QB  = NORMAL_FRAC_BITS + 1;
    localparam int KB  = $clog2(NORMAL_FRAC_BITS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_ABS, S_NORM, S_SQM, S_SQA, S_SQRT, S_DIVI, S_DIV, S_DONE
    } t_state;

    t_state                     r_state;
    logic [1:0]                 r_pt;
    logic [1:0]                 r_comp;
    logic signed [ACC_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0] r_acc [3];
    logic [ACC_BITS-1:0]        r_mg [3];
    logic [2:0]                 r_neg;
    logic [ACC_BITS-1:0]        r_sq;
    logic [ACC_BITS-1:0]        r_root;
    logic [ACC_BITS-1:0]        r_bit;
    logic [ACC_BITS-1:0]        r_rem;
    logic [ACC_BITS-1:0]        r_dv;
    logic [QB-1:0]              r_q;
    logic [KB-1:0]              r_k;
    logic [NB-1:0]              r_norm [3];
    logic                       r_degen;

    logic [1:0]                 pt_nx;
    logic [1:0]                 ca;
    logic [1:0]                 cb;
    logic signed [COORD_BITS-1:0] a0, b0, a1, b1;
    logic signed [COORD_BITS:0] dfull, sfull;
    logic signed [DW-1:0]       dtr, str;
    logic signed [MUL_BITS-1:0] op_a, op_b;
    logic                       mg_hi, mg_lo;
    logic [ACC_BITS-1:0]        sq_try;
    logic                       ge;
    logic [QB-1:0]              q_nx;
    logic [NB-1:0]              qe;

    always_comb begin
        pt_nx = (3'(r_pt) + 3'd1 == i_cnt) ? 2'd0 : r_pt + 2'd1;
        ca    = (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
        cb    = (r_comp == 2'd0) ? 2'd2 : r_comp - 2'd1;
        a0    = i_pts[r_pt][ca];
        b0    = i_pts[pt_nx][ca];
        a1    = i_pts[r_pt][cb];
        b1    = i_pts[pt_nx][cb];
        dfull = (COORD_BITS+1)'(a0) - (COORD_BITS+1)'(b0);
        sfull = (COORD_BITS+1)'(a1) + (COORD_BITS+1)'(b1);
        dtr   = DW'(dfull >>> PRE);
        str   = DW'(sfull >>> PRE);
        if (r_state == S_SQM) begin
            op_a = signed'(r_mg[r_comp][MUL_BITS-1:0]);
            op_b = signed'(r_mg[r_comp][MUL_BITS-1:0]);
        end else begin
            op_a = MUL_BITS'(dtr);
            op_b = MUL_BITS'(str);
        end
        mg_hi  = |{r_mg[0][ACC_BITS-1:31], r_mg[1][ACC_BITS-1:31], r_mg[2][ACC_BITS-1:31]};
        mg_lo  = ~|{r_mg[0][ACC_BITS-1:30], r_mg[1][ACC_BITS-1:30], r_mg[2][ACC_BITS-1:30]};
        sq_try = r_root + r_bit;
        ge     = (r_rem >= r_dv);
        q_nx   = {r_q[QB-2:0], ge};
        qe     = NB'(q_nx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_degen <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_pt    <= 2'd0;
                        r_comp  <= 2'd0;
                        r_degen <= 1'b0;
                        for (int j = 0; j < 3; j++) begin
                            r_acc[j] <= '0;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= op_a * op_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc[r_comp] <= r_acc[r_comp] + r_prod;
                    if (r_comp == 2'd2) begin
                        r_comp <= 2'd0;
                        r_pt   <= r_pt + 2'd1;
                        r_state <= (3'(r_pt) + 3'd1 == i_cnt) ? S_ABS : S_MUL;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_ABS: begin
                    for (int j = 0; j < 3; j++) begin
                        r_mg[j]  <= r_acc[j][ACC_BITS-1] ? unsigned'(-r_acc[j])
                                                          : unsigned'(r_acc[j]);
                        r_neg[j] <= r_acc[j][ACC_BITS-1];
                    end
                    if (r_acc[0] == '0 && r_acc[1] == '0 && r_acc[2] == '0) begin
                        r_degen <= 1'b1;
                        for (int j = 0; j < 3; j++) begin
                            r_norm[j] <= '0;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (mg_hi) begin
                        for (int j = 0; j < 3; j++) begin
                            r_mg[j] <= r_mg[j] >> 1;
                        end
                    end else if (mg_lo) begin
                        for (int j = 0; j < 3; j++) begin
                            r_mg[j] <= r_mg[j] << 1;
                        end
                    end else begin
                        r_comp  <= 2'd0;
                        r_sq    <= '0;
                        r_state <= S_SQM;
                    end
                end
                S_SQM: begin
                    r_prod  <= op_a * op_b;
                    r_state <= S_SQA;
                end
                S_SQA: begin
                    r_sq <= r_sq + unsigned'(r_prod);
                    if (r_comp == 2'd2) begin
                        r_root  <= '0;
                        r_bit   <= ACC_BITS'(1) << 62;
                        r_state <= S_SQRT;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_SQM;
                    end
                end
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_comp  <= 2'd0;
                        r_state <= S_DIVI;
                    end else begin
                        if (r_sq >= sq_try) begin
                            r_sq   <= r_sq - sq_try;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_DIVI: begin
                    r_rem   <= (r_mg[r_comp] << NORMAL_FRAC_BITS) + (r_root >> 1);
                    r_dv    <= r_root << NORMAL_FRAC_BITS;
                    r_k     <= KB'(NORMAL_FRAC_BITS);
                    r_q     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (ge) begin
                        r_rem <= r_rem - r_dv;
                    end
                    r_q  <= q_nx;
                    r_dv <= r_dv >> 1;
                    if (r_k == '0) begin
                        r_norm[r_comp] <= r_neg[r_comp] ? qe : NB'(-qe);
                        if (r_comp == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_state <= S_DIVI;
                        end
                    end else begin
                        r_k <= r_k - KB'(1);
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done  = (r_state == S_DONE);
    assign o_degen = r_degen;
    assign o_norm  = r_norm;
endmodule

[rtl/core/grid_vertex_normal_newell.sv]
// ----------------------------------------------------------------------------
// grid_vertex_normal_newell
// streamed grid vertex normals by newell's method
// ----------------------------------------------------------------------------
// Vertices enter in raster order, one request at a time; the block drops
// tready until every normal that the vertex completes has been taken, and
// while a config write is offered. Each vertex completes zero to four
// normals: the one shared 32x32 multiplier does the cross terms and
// squares, normalization shifts one bit per cycle, and the square root
// and the three divides retire one bit per cycle. Degenerate sums skip
// the root and divides. A config write to the grid width or height
// returns the grid position to the first vertex and leaves the line
// store as it was.
// ----------------------------------------------------------------------------
module grid_vertex_normal_newell #(
    parameter int MAX_WIDTH        = grvn_pkg::MAX_WIDTH_DEF,
    parameter int COORD_BITS       = grvn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = grvn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // pos_x, pos_y, pos_z
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // vert_col, vert_row, norm_x, norm_y, norm_z
    output logic [(($clog2(MAX_WIDTH)+grvn_pkg::GRID_H_BITS
                    +3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] o_m_axis_tdata,
    output logic                                  o_m_axis_tlast,
    // degenerate
    output logic                                  o_m_axis_tuser,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [grvn_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [grvn_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import grvn_pkg::*;

    localparam int CB     = $clog2(MAX_WIDTH);
    localparam int WB     = $clog2(MAX_WIDTH + 1);
    localparam int RB     = GRID_H_BITS;
    localparam int NB     = NORMAL_FRAC_BITS + 2;
    localparam int VW     = 3 * COORD_BITS;
    localparam int OUT_F  = CB + RB + 3 * NB;
    localparam int OUT_TD = ((OUT_F + 7) / 8) * 8;

    typedef enum logic [2:0] {T_IDLE, T_RD, T_LD, T_PICK, T_CALC, T_OUT, T_END} t_state;

    t_state                      r_state;
    logic [GRID_W_BITS-1:0]      r_gw;
    logic [RB-1:0]               r_gh;
    logic [CB-1:0]               r_col;
    logic [RB-1:0]               r_row;
    logic [CB-1:0]               r_c;
    logic [RB-1:0]               r_r;
    logic [VW-1:0]               r_cur;
    logic [VW-1:0]               r_up;
    logic [VW-1:0]               r_al;
    logic [VW-1:0]               r_cl;
    logic [3:0]                  r_pend;
    logic signed [COORD_BITS-1:0] r_pts [4][3];
    logic [2:0]                  r_cnt;
    logic                        r_ovalid;
    logic                        r_olast;
    logic                        r_odegen;
    logic [CB-1:0]               r_ocol;
    logic [RB-1:0]               r_orow;
    logic [NB-1:0]               r_onorm [3];

    logic [WB-1:0]               w_eff;
    logic [RB-1:0]               h_eff;
    logic [CB-1:0]               c_cl;
    logic [RB-1:0]               r_clmp;
    logic                        last_col;
    logic                        last_row;
    logic                        col_wrap;
    logic                        row_wrap;
    logic [VW-1:0]               sel_v [4];
    logic [2:0]                  sel_cnt;
    logic [CB-1:0]               sel_col;
    logic [RB-1:0]               sel_row;
    logic [3:0]                  sel_bit;
    logic                        s_acc;
    logic                        nrm_start;
    logic                        nrm_done;
    logic                        nrm_degen;
    logic [NB-1:0]               nrm_out [3];
    logic [VW-1:0]               ram_q;

    always_comb begin
        if (r_gw == '0) begin
            w_eff = WB'(1);
        end else if (32'(r_gw) > 32'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(r_gw);
        end
        h_eff    = (r_gh == '0) ? RB'(1) : r_gh;
        c_cl     = (WB'(r_col) >= w_eff) ? '0 : r_col;
        r_clmp   = (r_row >= h_eff) ? '0 : r_row;
        last_col = (WB'(r_c) + WB'(1) == w_eff);
        last_row = ((RB+1)'(r_r) + (RB+1)'(1) == (RB+1)'(h_eff));
        col_wrap = (WB'(r_c) + WB'(1) >= w_eff);
        row_wrap = ((RB+1)'(r_r) + (RB+1)'(1) >= (RB+1)'(h_eff));

        sel_v[0] = r_cur;
        sel_v[1] = r_cur;
        sel_v[2] = r_cur;
        sel_v[3] = r_cur;
        if (r_pend[0]) begin
            sel_v[0] = r_al;
            sel_v[1] = r_up;
            sel_v[3] = r_cl;
            sel_cnt  = 3'd4;
            sel_col  = r_c - CB'(1);
            sel_row  = r_r - RB'(1);
            sel_bit  = 4'b0001;
        end else if (r_pend[1]) begin
            sel_v[0] = r_up;
            sel_cnt  = 3'd2;
            sel_col  = r_c;
            sel_row  = r_r - RB'(1);
            sel_bit  = 4'b0010;
        end else if (r_pend[2]) begin
            sel_v[0] = r_cl;
            sel_cnt  = 3'd2;
            sel_col  = r_c - CB'(1);
            sel_row  = r_r;
            sel_bit  = 4'b0100;
        end else begin
            sel_cnt  = 3'd1;
            sel_col  = r_c;
            sel_row  = r_r;
            sel_bit  = 4'b1000;
        end
    end

    assign s_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign nrm_start = (r_state == T_PICK) && (r_pend != '0);

    grvn_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (r_state == T_LD),
        .i_waddr (r_c),
        .i_wdata (r_cur),
        .i_re    (r_state == T_RD),
        .i_raddr (r_c),
        .o_rdata (ram_q)
    );

    grvn_norm #(
        .COORD_BITS       (COORD_BITS),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (nrm_start),
        .i_pts   (r_pts),
        .i_cnt   (r_cnt),
        .o_done  (nrm_done),
        .o_degen (nrm_degen),
        .o_norm  (nrm_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_gw     <= GRID_W_RST;
            r_gh     <= GRID_H_RST;
            r_col    <= '0;
            r_row    <= '0;
            r_al     <= '0;
            r_cl     <= '0;
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_GRID_WIDTH) begin
                    r_gw  <= i_cfg_data[GRID_W_BITS-1:0];
                    r_col <= '0;
                    r_row <= '0;
                end else if (i_cfg_index == CFG_GRID_HEIGHT) begin
                    r_gh  <= i_cfg_data[RB-1:0];
                    r_col <= '0;
                    r_row <= '0;
                end
            end
            case (r_state)
                T_IDLE: begin
                    if (s_acc) begin
                        r_cur   <= i_s_axis_tdata[VW-1:0];
                        r_c     <= c_cl;
                        r_r     <= r_clmp;
                        r_state <= T_RD;
                    end
                end
                T_RD: begin
                    r_state <= T_LD;
                end
                T_LD: begin
                    r_up    <= ram_q;
                    r_pend  <= {last_row && last_col, last_row && (r_c != '0),
                                (r_r != '0) && last_col, (r_r != '0) && (r_c != '0)};
                    r_state <= T_PICK;
                end
                T_PICK: begin
                    if (r_pend == '0) begin
                        r_state <= T_END;
                    end else begin
                        for (int p = 0; p < 4; p++) begin
                            for (int k = 0; k < 3; k++) begin
                                r_pts[p][k] <= sel_v[p][k*COORD_BITS +: COORD_BITS];
                            end
                        end
                        r_cnt   <= sel_cnt;
                        r_ocol  <= sel_col;
                        r_orow  <= sel_row;
                        r_olast <= ((r_pend & ~sel_bit) == '0);
                        r_pend  <= r_pend & ~sel_bit;
                        r_state <= T_CALC;
                    end
                end
                T_CALC: begin
                    if (nrm_done) begin
                        r_onorm  <= nrm_out;
                        r_odegen <= nrm_degen;
                        r_ovalid <= 1'b1;
                        r_state  <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (i_m_axis_tready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= T_PICK;
                    end
                end
                T_END: begin
                    r_al <= r_up;
                    r_cl <= r_cur;
                    if (col_wrap) begin
                        r_col <= '0;
                        r_row <= row_wrap ? '0 : r_r + RB'(1);
                    end else begin
                        r_col <= r_c + CB'(1);
                        r_row <= r_r;
                    end
                    r_state <= T_IDLE;
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == T_IDLE) && !i_cfg_valid;
    assign o_cfg_ready     = (r_state == T_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_odegen;
    assign o_m_axis_tdata  = OUT_TD'({r_onorm[2], r_onorm[1], r_onorm[0], r_orow, r_ocol});

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input accepted while a result is pending");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
        (r_onorm[0] == '0 && r_onorm[1] == '0 && r_onorm[2] == '0))
        else $error("degenerate result with nonzero normal");

    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (r_pend == '0))
        else $error("last result marked while results remain");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WB'(r_col) < w_eff)
        else $error("column counter past grid width");
endmodule
